// ===== rtl/sit_pkg.sv =====
package sit_pkg;

  // fixed field widths of the ports
  localparam int OP_W       = 2;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 6;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // defaults for the top-level parameters
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_ORDER = 1'd1;

  // controller -> datapath
  typedef struct packed {
    logic    load_ins;
    logic    load_rem;
    logic    read_issue;
    logic    search_rd;
    logic    search_cmp;
    logic    shift_up;
    logic    shift_dn;
    logic    put_key;
    logic    finish;
    status_t status;
    cnt_op_t cnt_op;
    logic    take_rdata;
  } sit_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic idx_bad;
    logic search_done;
    logic up_done;
    logic dn_done;
  } sit_stat_t;

endpackage

// ===== rtl/sit_ram.sv =====
module sit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sit_ctrl.sv =====
module sit_ctrl
  import sit_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_op,
  input  sit_stat_t       stat,
  output sit_cmd_t        cmd,
  output logic            busy
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SRCH_RD   = 6'b000010,
    ST_SRCH_CMP  = 6'b000100,
    ST_SHIFT_UP  = 6'b001000,
    ST_SHIFT_DN  = 6'b010000,
    ST_READ_WAIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op_t'(in_op))
            OP_INSERT: begin
              if (stat.full) begin
                cmd.finish = 1'b1;
                cmd.status = STAT_FULL;
              end else begin
                cmd.load_ins = 1'b1;
                state_nxt    = ST_SRCH_RD;
              end
            end
            OP_REMOVE: begin
              if (stat.idx_bad) begin
                cmd.finish = 1'b1;
                cmd.status = STAT_RANGE;
              end else begin
                cmd.load_rem = 1'b1;
                state_nxt    = ST_SHIFT_DN;
              end
            end
            OP_READ: begin
              if (stat.idx_bad) begin
                cmd.finish = 1'b1;
                cmd.status = STAT_RANGE;
              end else begin
                cmd.read_issue = 1'b1;
                state_nxt      = ST_READ_WAIT;
              end
            end
            OP_CLEAR: begin
              cmd.finish = 1'b1;
              cmd.cnt_op = CNT_CLR;
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      ST_SRCH_RD: begin
        cmd.search_rd = 1'b1;
        state_nxt     = stat.search_done ? ST_SHIFT_UP : ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        cmd.search_cmp = 1'b1;
        state_nxt      = ST_SRCH_RD;
      end
      ST_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
        if (stat.up_done) begin
          // store the key at the lower bound once the gap is open
          cmd.put_key = 1'b1;
          cmd.finish  = 1'b1;
          cmd.cnt_op  = CNT_INC;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SHIFT_DN: begin
        cmd.shift_dn = 1'b1;
        if (stat.dn_done) begin
          cmd.finish = 1'b1;
          cmd.cnt_op = CNT_DEC;
          state_nxt  = ST_IDLE;
        end
      end
      ST_READ_WAIT: begin
        cmd.finish     = 1'b1;
        cmd.take_rdata = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/sit_dp.sv =====
module sit_dp
  import sit_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sit_cmd_t              cmd,
  output sit_stat_t             stat,
  input  logic [VAL_W-1:0]      in_item_value,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [VAL_W-1:0]      out_read_value,
  output logic [CNT_W-1:0]      out_entry_count
);

  localparam int AW  = $clog2(DEPTH);
  localparam int PW0 = $clog2(DEPTH + 1);
  localparam int PW  = (PW0 > CNT_W) ? PW0 : CNT_W;
  localparam int XW  = KEY_WIDTH + VAL_W;

  logic [CNT_W-1:0]     max_entries_r;
  logic                 signed_order_r;

  logic [PW-1:0]        count_r, count_nxt;
  logic [PW-1:0]        lo_r, lo_nxt;
  logic [PW-1:0]        hi_r, hi_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r;

  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [VAL_W-1:0]     out_read_value_r;
  logic [CNT_W-1:0]     out_entry_count_r;

  logic [PW-1:0]        mid, ptr_inc, ptr_dec, idx_ext;
  logic                 lo_lt_hi, ptr_gt_lo, dn_more, key_lt;
  logic [XW-1:0]        key_wide, rd_wide;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

  sit_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign ptr_inc   = ptr_r + PW'(1);
  assign ptr_dec   = ptr_r - PW'(1);
  assign idx_ext   = PW'(in_entry_index);
  assign lo_lt_hi  = (lo_r < hi_r);
  assign ptr_gt_lo = (ptr_r > lo_r);
  assign dn_more   = (ptr_inc < count_r);

  assign key_wide = {KEY_WIDTH'(0), in_item_value};
  assign rd_wide  = {VAL_W'(0), ram_rdata};

  assign key_lt = signed_order_r ? ($signed(ram_rdata) < $signed(key_r))
                                 : (ram_rdata < key_r);

  assign stat.full        = (count_r >= PW'(max_entries_r)) || (count_r >= PW'(DEPTH));
  assign stat.idx_bad     = (idx_ext >= count_r);
  assign stat.search_done = !lo_lt_hi;
  assign stat.up_done     = !ptr_gt_lo && !pend_r;
  assign stat.dn_done     = !dn_more && !pend_r;

  always_comb begin
    ram_raddr = '0;
    if (cmd.search_rd) begin
      ram_raddr = mid[AW-1:0];
    end else if (cmd.read_issue) begin
      ram_raddr = idx_ext[AW-1:0];
    end else if (cmd.shift_up) begin
      ram_raddr = ptr_dec[AW-1:0];
    end else if (cmd.shift_dn) begin
      ram_raddr = ptr_inc[AW-1:0];
    end
  end

  // a shift writes the word read in the previous cycle
  assign ram_we    = cmd.put_key || (pend_r && (cmd.shift_up || cmd.shift_dn));
  assign ram_waddr = cmd.put_key ? lo_r[AW-1:0] : pend_addr_r;
  assign ram_wdata = cmd.put_key ? key_r : ram_rdata;

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    ptr_nxt = ptr_r;
    key_nxt = key_r;
    if (cmd.load_ins || cmd.load_rem) begin
      lo_nxt  = '0;
      hi_nxt  = count_r;
      ptr_nxt = cmd.load_ins ? count_r : idx_ext;
      key_nxt = key_wide[KEY_WIDTH-1:0];
    end
    if (cmd.search_cmp) begin
      if (key_lt) begin
        lo_nxt = mid + PW'(1);
      end else begin
        hi_nxt = mid;
      end
    end
    if (cmd.shift_up && ptr_gt_lo) begin
      ptr_nxt = ptr_dec;
    end
    if (cmd.shift_dn && dn_more) begin
      ptr_nxt = ptr_inc;
    end
  end

  always_comb begin
    pend_nxt = 1'b0;
    if (cmd.shift_up) begin
      pend_nxt = ptr_gt_lo;
    end else if (cmd.shift_dn) begin
      pend_nxt = dn_more;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish) begin
      case (cmd.cnt_op)
        CNT_KEEP: count_nxt = count_r;
        CNT_INC:  count_nxt = count_r + PW'(1);
        CNT_DEC:  count_nxt = count_r - PW'(1);
        CNT_CLR:  count_nxt = '0;
        default:  count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r  <= MAX_ENTRIES_RST;
      signed_order_r <= 1'b0;
      count_r        <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ENTRIES:  max_entries_r  <= cfg_data[CNT_W-1:0];
          REG_SIGNED_ORDER: signed_order_r <= cfg_data[0];
          default: ;
        endcase
      end
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ptr_r       <= ptr_nxt;
    key_r       <= key_nxt;
    pend_addr_r <= ptr_r[AW-1:0];
    if (cmd.finish) begin
      out_status_r      <= cmd.status;
      out_read_value_r  <= cmd.take_rdata ? rd_wide[VAL_W-1:0] : '0;
      out_entry_count_r <= count_nxt[CNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

endmodule

// ===== rtl/sorted_insertion_table.sv =====
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+---------------------------
// input    | in_op, in_item_value, in_entry_index         | start high, busy low
// result   | out_status, out_read_value, out_entry_count  | out_valid, one-cycle strobe
// config   | cfg_index, cfg_data                          | cfg_valid and cfg_ready
//
// One word per operation, the result strobed in the cycle after the operation ends.
// Clear, a rejected insert and an out-of-range index end in the accept cycle; a read
// waits for the registered-read key RAM; a remove at index i shifts the entries above
// it down one at a time; an insert runs a binary search over the registered-read key
// RAM, each step a read and then a compare, then shifts entries up one at a time and
// stores the key at the lower bound.
// rst_n is synchronous; the key RAM is not cleared, the entry count guards it.
// The receiver cannot stall; cfg_ready is always high.
module sorted_insertion_table
  import sit_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [VAL_W-1:0]      in_item_value,
  input  logic [IDX_W-1:0]      in_entry_index,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [VAL_W-1:0]      out_read_value,
  output logic [CNT_W-1:0]      out_entry_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sit_cmd_t  cmd;
  sit_stat_t stat;

  assign cfg_ready = 1'b1;

  sit_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sit_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_item_value   (in_item_value),
    .in_entry_index  (in_entry_index),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int          TABLE_DEPTH = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    status_t             status;
    logic [VAL_W-1:0]    read_value;
    logic [CNT_W-1:0]    entry_count;
  } table_result_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_op          = '0;
  logic [VAL_W-1:0]      in_item_value  = '0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [VAL_W-1:0]      out_read_value;
  logic [CNT_W-1:0]      out_entry_count;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // mirror of the table contents and registers
  logic [VAL_W-1:0] mirror_keys [TABLE_DEPTH];
  int unsigned      mirror_count  = 0;
  logic [CNT_W-1:0] mirror_cap    = MAX_ENTRIES_RST;
  bit               mirror_signed = 1'b0;

  table_result_t pending_results [$];
  table_result_t want_res;
  int unsigned   err_count    = 0;
  int unsigned   cycle_count  = 0;
  bit            sender_idles = 1'b1;

  sorted_insertion_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_item_value   (in_item_value),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit key_below(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    if (mirror_signed) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  // update the mirror for one accepted word and return the result it should produce
  function automatic table_result_t apply_table_op(op_t op, logic [VAL_W-1:0] key,
                                                   logic [IDX_W-1:0] idx);
    table_result_t res;
    int unsigned   lo, hi, mid, lim, i;
    res.status     = STAT_OK;
    res.read_value = '0;
    lim = (mirror_cap > TABLE_DEPTH) ? TABLE_DEPTH : mirror_cap;
    case (op)
      OP_INSERT: begin
        if (mirror_count >= lim) begin
          res.status = STAT_FULL;
        end else begin
          // binary search exactly as the block does; the table may be unsorted
          // under the current order after signed_order changed
          lo = 0;
          hi = mirror_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_below(mirror_keys[mid], key)) lo = mid + 1;
            else hi = mid;
          end
          for (i = mirror_count; i > lo; i--) mirror_keys[i] = mirror_keys[i - 1];
          mirror_keys[lo] = key;
          mirror_count++;
        end
      end
      OP_REMOVE: begin
        if (idx >= mirror_count) begin
          res.status = STAT_RANGE;
        end else begin
          for (i = idx; i + 1 < mirror_count; i++) mirror_keys[i] = mirror_keys[i + 1];
          mirror_count--;
        end
      end
      OP_READ: begin
        if (idx >= mirror_count) res.status = STAT_RANGE;
        else res.read_value = mirror_keys[idx];
      end
      default: begin
        for (i = 0; i < TABLE_DEPTH; i++) mirror_keys[i] = '0;
        mirror_count = 0;
      end
    endcase
    res.entry_count = CNT_W'(mirror_count);
    return res;
  endfunction

  // few distinct values so equal keys show up often
  function automatic logic [VAL_W-1:0] pick_key();
    int unsigned r, k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    if (r < 25) return (k[0] ? 32'hF000_0000 : 32'h0) | VAL_W'(k);
    if (r < 40) begin
      case (k[1:0])
        2'd0:    return '0;
        2'd1:    return '1;
        2'd2:    return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (mirror_count != 0 && $urandom_range(0, 99) < 80)
      return IDX_W'($urandom_range(0, mirror_count - 1));
    return IDX_W'($urandom());
  endfunction

  task automatic send_op(op_t op, logic [VAL_W-1:0] key, logic [IDX_W-1:0] idx);
    while (sender_idles && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_item_value  <= key;
    in_entry_index <= idx;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_table_op(op, key, idx));
  endtask

  // hold off until every result is back and the block is idle
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MAX_ENTRIES) mirror_cap = data;
    else mirror_signed = data[0];
  endtask

  task automatic set_config(logic [CNT_W-1:0] cap, bit sgn);
    logic [CFG_DATA_W-1:0] order_bits;
    settle();
    // upper bits of the order word are don't-care
    order_bits    = CFG_DATA_W'($urandom());
    order_bits[0] = sgn;
    write_reg(REG_MAX_ENTRIES, cap);
    write_reg(REG_SIGNED_ORDER, order_bits);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_mix(int unsigned n);
    int unsigned k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_op(OP_INSERT, pick_key(), IDX_W'($urandom()));
      else if (r < 65) send_op(OP_REMOVE, $urandom(), pick_index());
      else if (r < 96) send_op(OP_READ, $urandom(), pick_index());
      else send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    end
  endtask

  task automatic test_extremes();
    int unsigned k;
    send_op(OP_READ, $urandom(), '0);
    send_op(OP_REMOVE, $urandom(), '0);
    send_op(OP_INSERT, 32'h8000_0000, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'hFFFF_FFFF, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h0000_0000, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h7FFF_FFFF, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h7FFF_FFFF, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h0000_0000, IDX_W'($urandom()));
    for (k = 0; k < 7; k++) send_op(OP_READ, $urandom(), IDX_W'(k));
    send_op(OP_READ, $urandom(), '1);
    send_op(OP_REMOVE, $urandom(), '1);
    send_op(OP_REMOVE, $urandom(), IDX_W'(5));
    send_op(OP_REMOVE, $urandom(), '0);
    send_op(OP_REMOVE, $urandom(), IDX_W'(1));
    send_op(OP_READ, $urandom(), IDX_W'(1));
    send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    send_op(OP_INSERT, 32'hFFFF_FFFF, IDX_W'($urandom()));
    send_op(OP_READ, $urandom(), '0);
  endtask

  task automatic test_signed_order();
    int unsigned k;
    set_config(MAX_ENTRIES_RST, 1'b1);
    send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h8000_0000, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h7FFF_FFFF, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'hFFFF_FFFF, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h0000_0000, IDX_W'($urandom()));
    send_op(OP_INSERT, 32'h0000_0001, IDX_W'($urandom()));
    // flip the order with entries stored, then insert into the stale order
    set_config(MAX_ENTRIES_RST, 1'b0);
    send_op(OP_INSERT, 32'h4000_0000, IDX_W'($urandom()));
    for (k = 0; k < 6; k++) send_op(OP_READ, $urandom(), IDX_W'(k));
  endtask

  task automatic test_capacity();
    int unsigned k;
    // a capacity above the depth acts as the depth
    set_config(7'd127, 1'b0);
    send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    for (k = 0; k < TABLE_DEPTH; k++) send_op(OP_INSERT, pick_key(), IDX_W'($urandom()));
    send_op(OP_INSERT, $urandom(), IDX_W'($urandom()));
    send_op(OP_READ, $urandom(), '1);
    send_op(OP_REMOVE, $urandom(), '1);
    send_op(OP_READ, $urandom(), '1);
    // capacity dropped below the stored count: inserts bounce until it shrinks
    set_config(7'd2, 1'b0);
    send_op(OP_INSERT, $urandom(), IDX_W'($urandom()));
    send_op(OP_REMOVE, $urandom(), '0);
    send_op(OP_READ, $urandom(), '0);
    send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    for (k = 0; k < 3; k++) send_op(OP_INSERT, pick_key(), IDX_W'($urandom()));
    set_config(7'd0, 1'b1);
    send_op(OP_INSERT, $urandom(), IDX_W'($urandom()));
    send_op(OP_READ, $urandom(), '0);
    send_op(OP_CLEAR, $urandom(), IDX_W'($urandom()));
    send_op(OP_INSERT, $urandom(), IDX_W'($urandom()));
  endtask

  task automatic test_random_phases();
    set_config(MAX_ENTRIES_RST, 1'b0);
    run_random_mix(110);
    // long stretch with a steady sender
    set_config(MAX_ENTRIES_RST, 1'b1);
    sender_idles = 1'b0;
    run_random_mix(110);
    sender_idles = 1'b1;
    set_config(7'd12, 1'b0);
    run_random_mix(50);
    settle();
    run_random_mix(50);
    set_config(CNT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    run_random_mix(60);
    set_config(7'd0, 1'b1);
    run_random_mix(25);
    set_config(7'd127, 1'b0);
    run_random_mix(30);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d read_value %h entry_count %0d",
               out_status, out_read_value, out_entry_count);
        err_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (out_status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_status);
          err_count++;
        end
        if (out_read_value !== want_res.read_value) begin
          $error("read_value: expected %h, got %h", want_res.read_value, out_read_value);
          err_count++;
        end
        if (out_entry_count !== want_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want_res.entry_count, out_entry_count);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (mirror_keys[i]) mirror_keys[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_signed_order();
    test_capacity();
    test_random_phases();
    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sit_pkg.sv
rtl/sit_ram.sv
rtl/sit_ctrl.sv
rtl/sit_dp.sv
rtl/sorted_insertion_table.sv
tb/sv/tb.sv
